FILE: src/triangle_sides_perimeter_area_unit_assert.svh
// assertion macros for the triangle unit
`ifndef TRIANGLE_SIDES_PERIMETER_AREA_UNIT_ASSERT_SVH
`define TRIANGLE_SIDES_PERIMETER_AREA_UNIT_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define TSPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tspa check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define TSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tspa check failed");

`endif

FILE: src/tspa_pkg.sv
// shared types and constants for the triangle unit
package tspa_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int SIDE_W  = 17;
	localparam int PERIM_W = 19;
	localparam int AREA_W  = 31;
	localparam int IDX_W   = 2;
	localparam logic [IDX_W-1:0] IDX_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SIDE, ST_SQRT, ST_HERON, ST_MUL, ST_AREA, ST_DONE
	} tspa_state_t;
endpackage

FILE: src/tspa_front.sv
// front: vertex store, update and squared side distances
module tspa_front #(
	parameter int COORD_BITS = tspa_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [tspa_pkg::IDX_W-1:0] vertex_index,
	input  logic signed [15:0] new_x,
	input  logic signed [15:0] new_y,
	output logic q_push,
	input  logic q_full,
	output logic [2*COORD_BITS+1:0] q_d2 [3]
);
	import tspa_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] vx_q [3];
	logic signed [COORD_BITS-1:0] vy_q [3];
	logic [1:0] ph_q;
	logic busy_q;
	logic signed [COORD_BITS-1:0] nx, ny;
	logic [1:0] i0, i1;
	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] ax, ay;
	logic [SW-1:0] acc_q [3];

	assign full = busy_q;
	assign nx = COORD_BITS'(new_x);
	assign ny = COORD_BITS'(new_y);

	always_comb begin
		i0 = ph_q;
		i1 = (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
		dx = DW'(vx_q[i0]) - DW'(vx_q[i1]);
		dy = DW'(vy_q[i0]) - DW'(vy_q[i1]);
		ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
		ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
	end

	// one side per cycle, then hand over when queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= 2'd0;
			for (int k = 0; k < 3; k++) begin
				vx_q[k] <= '0;
				vy_q[k] <= '0;
			end
		end else if (!busy_q) begin
			if (push) begin
				busy_q <= 1'b1;
				ph_q <= 2'd0;
				if (vertex_index != IDX_NONE) begin
					vx_q[vertex_index] <= nx;
					vy_q[vertex_index] <= ny;
				end
			end
		end else if (ph_q != 2'd3) begin
			ph_q <= ph_q + 2'd1;
		end else if (!q_full) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && ph_q != 2'd3)
			acc_q[ph_q] <= SW'(ax * ax) + SW'(ay * ay);
	end

	assign q_push = busy_q && ph_q == 2'd3 && !q_full;
	assign q_d2 = acc_q;
endmodule

FILE: src/tspa_back.sv
// back: square roots, perimeter and heron area
module tspa_back #(
	parameter int COORD_BITS = tspa_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	output logic q_pop,
	input  logic [2*COORD_BITS+1:0] q_d2 [3],
	output logic empty,
	input  logic pop,
	output logic [tspa_pkg::SIDE_W-1:0] side_a,
	output logic [tspa_pkg::SIDE_W-1:0] side_b,
	output logic [tspa_pkg::SIDE_W-1:0] side_c,
	output logic [tspa_pkg::PERIM_W-1:0] perimeter,
	output logic [tspa_pkg::AREA_W-1:0] area
);
	import tspa_pkg::*;

	localparam int SW = 2 * COORD_BITS + 2;
	localparam int LW = COORD_BITS + 1;     // side width
	localparam int PW = LW + 2;             // perimeter / factor width
	localparam int XW = 2 * PW;             // pair product
	localparam int NW = 4 * PW;             // heron product
	localparam int RW = 2 * PW;             // sqrt result bits
	localparam int CW = $clog2(RW + 1);
	localparam int MH = PW;                 // multiply split half width

	tspa_state_t st_q, st_d;
	logic [SW-1:0] d2_q [3];
	logic [1:0] si_q;
	logic [CW-1:0] bit_q;
	logic [NW-1:0] rad_q;
	logic [RW-1:0] root_q;
	logic [NW+1:0] rem_q;
	logic [LW-1:0] s_q [3];
	logic [PW-1:0] f_q [4];
	logic [XW-1:0] x1_q, x2_q;
	logic [1:0] mph_q;
	logic [NW-1:0] prod_q;
	logic ok_q;
	logic out_v_q;
	logic [SIDE_W-1:0] oa_q, ob_q, oc_q;
	logic [PERIM_W-1:0] op_q;
	logic [AREA_W-1:0] oar_q;

	// restoring square root, one result bit per cycle
	logic [NW+1:0] trial;
	logic [NW+1:0] rem_sh;
	logic [NW-1:0] rad_sh;
	logic [XW-1:0] ma;
	logic [MH-1:0] mb;
	logic [XW+MH-1:0] mprod;
	logic [PW-1:0] pa, pb, pc, pp;

	always_comb begin
		rem_sh = {rem_q[NW-1:0], rad_q[NW-1 -: 2]};
		rad_sh = {rad_q[NW-3:0], 2'b00};
		trial = (NW+2)'({root_q, 2'b01});
		pa = PW'(s_q[0]);
		pb = PW'(s_q[1]);
		pc = PW'(s_q[2]);
		pp = pa + pb + pc;
		ma = x1_q;
		mb = mph_q[0] ? x2_q[XW-1 -: MH] : x2_q[MH-1:0];
		mprod = ma * mb;
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		case (st_q)
			ST_IDLE:  if (!q_empty && !out_v_q) begin
				st_d = ST_SIDE;
				q_pop = 1'b1;
			end
			ST_SIDE:  st_d = ST_SQRT;
			ST_SQRT:  if (bit_q == '0)
				st_d = (si_q == 2'd3) ? ST_DONE : (si_q == 2'd2) ? ST_HERON : ST_SIDE;
			ST_HERON: st_d = ST_MUL;
			ST_MUL:   if (mph_q == 2'd1) st_d = ST_AREA;
			ST_AREA:  st_d = ST_SQRT;
			ST_DONE:  st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_DONE) out_v_q <= 1'b1;
			else if (pop && out_v_q) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (q_pop) d2_q <= q_d2;
				si_q <= 2'd0;
			end
			ST_SIDE: begin
				rad_q <= NW'(d2_q[si_q]);
				root_q <= '0;
				rem_q <= '0;
				bit_q <= CW'(RW);
			end
			ST_SQRT: begin
				if (bit_q != '0) begin
					rad_q <= rad_sh;
					bit_q <= bit_q - CW'(1);
					if (rem_sh >= trial) begin
						rem_q <= rem_sh - trial;
						root_q <= {root_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						root_q <= {root_q[RW-2:0], 1'b0};
					end
				end else begin
					if (si_q != 2'd3) s_q[si_q] <= LW'(root_q);
					si_q <= si_q + 2'd1;
				end
			end
			ST_HERON: begin
				ok_q <= (pb + pc > pa) && (pa + pc > pb) && (pa + pb > pc);
				f_q[0] <= pp;
				f_q[1] <= pb + pc - pa;
				f_q[2] <= pa + pc - pb;
				f_q[3] <= pa + pb - pc;
				mph_q <= 2'd0;
			end
			ST_MUL: begin
				if (mph_q == 2'd0) begin
					x1_q <= XW'(f_q[0] * f_q[1]);
					x2_q <= XW'(f_q[2] * f_q[3]);
					prod_q <= '0;
					mph_q <= 2'd2;
				end else if (mph_q == 2'd2) begin
					prod_q <= NW'(mprod);
					mph_q <= 2'd3;
				end else if (mph_q == 2'd3) begin
					prod_q <= prod_q + (NW'(mprod) << MH);
					mph_q <= 2'd1;
				end
			end
			ST_AREA: begin
				rad_q <= ok_q ? prod_q : '0;
				root_q <= '0;
				rem_q <= '0;
				bit_q <= CW'(RW);
			end
			ST_DONE: begin
				oa_q <= (LW > SIDE_W && (s_q[0] >> SIDE_W) != '0) ? '1 : SIDE_W'(s_q[0]);
				ob_q <= (LW > SIDE_W && (s_q[1] >> SIDE_W) != '0) ? '1 : SIDE_W'(s_q[1]);
				oc_q <= (LW > SIDE_W && (s_q[2] >> SIDE_W) != '0) ? '1 : SIDE_W'(s_q[2]);
				op_q <= (PW > PERIM_W && (pp >> PERIM_W) != '0) ? '1 : PERIM_W'(pp);
				oar_q <= ((RW - 2 > AREA_W) && ((root_q >> (AREA_W + 2)) != '0))
					? '1 : AREA_W'(root_q >> 2);
			end
			default: ;
		endcase
	end

	assign empty = !out_v_q;
	assign side_a = oa_q;
	assign side_b = ob_q;
	assign side_c = oc_q;
	assign perimeter = op_q;
	assign area = oar_q;

	`include "triangle_sides_perimeter_area_unit_assert.svh"
	`TSPA_ASSERT_IMP(a_pop_idle, clk, arst_n, q_pop, st_q == ST_IDLE && !out_v_q)
	`TSPA_ASSERT_NEXT(a_done_valid, clk, arst_n, st_q == ST_DONE, out_v_q)
	`TSPA_ASSERT_IMP(a_no_start_busy, clk, arst_n, out_v_q, !q_pop)
endmodule

FILE: src/tspa_queue.sv
// short queue of squared side distances between front and back
module tspa_queue #(
	parameter int DW = 34
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	output logic full,
	input  logic [DW-1:0] wd [3],
	input  logic rd,
	output logic empty,
	output logic [DW-1:0] rdata [3]
);
	logic [DW-1:0] m_q [2][3];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = m_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) m_q[wp_q] <= wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !full) wp_q <= !wp_q;
			if (rd && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
		end
	end
endmodule

FILE: src/triangle_sides_perimeter_area_unit.sv
// top level of the triangle side, perimeter and heron area unit
//  channel | direction | transaction
//  vertex  | in        | push && !full : vertex_index, new_x, new_y
//  result  | out       | pop && !empty : side_a, side_b, side_c, perimeter, area
// the front computes one squared side per cycle, then waits for queue room
// the back runs three side roots and one area root, one result bit a cycle
// a two-entry queue lets the front take a new vertex while the back works
// reset clears the stored vertices to zero and empties queue and result
module triangle_sides_perimeter_area_unit #(
	parameter int COORD_BITS = tspa_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [tspa_pkg::IDX_W-1:0] vertex_index,
	input  logic signed [15:0] new_x,
	input  logic signed [15:0] new_y,
	output logic empty,
	input  logic pop,
	output logic [tspa_pkg::SIDE_W-1:0] side_a,
	output logic [tspa_pkg::SIDE_W-1:0] side_b,
	output logic [tspa_pkg::SIDE_W-1:0] side_c,
	output logic [tspa_pkg::PERIM_W-1:0] perimeter,
	output logic [tspa_pkg::AREA_W-1:0] area
);
	import tspa_pkg::*;

	localparam int SW = 2 * COORD_BITS + 2;

	// front to queue
	logic f_push, f_full;
	logic [SW-1:0] f_d2 [3];
	// queue to back
	logic b_pop, b_empty;
	logic [SW-1:0] b_d2 [3];

	tspa_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .push, .full, .vertex_index, .new_x, .new_y,
		.q_push(f_push), .q_full(f_full), .q_d2(f_d2)
	);

	tspa_queue #(.DW(SW)) u_queue (
		.clk, .arst_n, .wr(f_push), .full(f_full), .wd(f_d2),
		.rd(b_pop), .empty(b_empty), .rdata(b_d2)
	);

	tspa_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .q_empty(b_empty), .q_pop(b_pop), .q_d2(b_d2),
		.empty, .pop, .side_a, .side_b, .side_c, .perimeter, .area
	);
endmodule
